### hdl/i2afmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2afmt_pkg: shared definitions of the integer to ASCII formatter
// Conversion kinds, character constants, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package i2afmt_pkg;

	localparam int MAX_RESULTS = 18;
	localparam int EMIT_W      = $clog2(MAX_RESULTS);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;  // '0'
	localparam logic [7:0] UPPER_OFS  = 8'd55;  // 'A' - 10
	localparam logic [7:0] LOWER_OFS  = 8'd87;  // 'a' - 10
	localparam logic [7:0] CHAR_MINUS = 8'd45;  // '-'
	localparam logic [7:0] CHAR_X     = 8'd120; // 'x'
	localparam logic [47:0] NULL_TEXT = "(null)";

	typedef enum logic [2:0] {
		KIND_SDEC = 3'd0,
		KIND_OCT  = 3'd1,
		KIND_UDEC = 3'd2,
		KIND_HEX  = 3'd3,
		KIND_PTR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		DM_OCT,
		DM_DEC,
		DM_HEXU,
		DM_HEXL
	} dmode_t;

	typedef enum logic [1:0] {
		PRE_NONE,
		PRE_MINUS,
		PRE_HEX,
		PRE_NULL
	} pre_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_MOVE,
		ST_SKIP,
		ST_PREFIX,
		ST_DIGITS
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic bcd_move;
		logic skip;
		logic emit_pre;
		logic emit_dig;
	} dp_cmd_t;

	typedef struct packed {
		logic kind_ok;
		logic in_dec;
		logic conv_last;
		logic skip_done;
		logic has_pre;
		logic pre_last;
		logic pre_end;
		logic dig_last;
		logic trunc;
		logic emit_ok;
	} dp_stat_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] dx;
		dx = {4'd0, d};
		if (d < 4'd10)
			return CHAR_ZERO + dx;
		else if (lower)
			return LOWER_OFS + dx;
		else
			return UPPER_OFS + dx;
	endfunction

	function automatic logic [2:0] prefix_len(input pre_t p);
		logic [2:0] n;
		unique case (p)
			PRE_MINUS: n = 3'd1;
			PRE_HEX:   n = 3'd2;
			PRE_NULL:  n = 3'd6;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] prefix_char(input pre_t p, input logic [2:0] idx);
		logic [7:0] c;
		unique case (p)
			PRE_MINUS: c = CHAR_MINUS;
			PRE_HEX:   c = (idx == 3'd0) ? CHAR_ZERO : CHAR_X;
			PRE_NULL: begin
				case (idx)
					3'd0:    c = NULL_TEXT[47:40];
					3'd1:    c = NULL_TEXT[39:32];
					3'd2:    c = NULL_TEXT[31:24];
					3'd3:    c = NULL_TEXT[23:16];
					3'd4:    c = NULL_TEXT[15:8];
					default: c = NULL_TEXT[7:0];
				endcase
			end
			default:   c = CHAR_ZERO;
		endcase
		return c;
	endfunction

endpackage

### hdl/integer_to_ascii_radix_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter: printf-style integer to text converter
// Formats signed or unsigned decimal, octal, upper-case hex or a pointer
// as 0x plus lower-case hex or (null), one ASCII char per output transaction.
// ----------------------------------------------------------------------------
// An item is taken when the block is idle. After the accept, the two decimal
// kinds run a shift-and-add-3 BCD conversion, one step per input bit, and
// then move the BCD digits back into the digit shift register; every kind
// then drops its leading zero digits one at a time and leaves the skip, and
// then writes its characters one at a time into the output register. An
// undefined kind writes no text and leaves the block idle. The digit shift
// register is shared by all kinds and the BCD converter is bit-serial;
// consumer stalls hold the writing of characters.
// The next item is accepted while the last character of the previous one
// still waits in the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter import i2afmt_pkg::*; #(
	parameter int INT_WIDTH = 32,
	parameter int PTR_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last_char
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	i2afmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	i2afmt_dp #(
		.INT_WIDTH (INT_WIDTH),
		.PTR_WIDTH (PTR_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_type  (req_type),
		.value     (value),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

### hdl/i2afmt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2afmt_dp: formatter datapath
// Digit shift register, binary to BCD converter, prefix and digit counters,
// and the output register that holds one character for the consumer.
// ----------------------------------------------------------------------------
module i2afmt_dp import i2afmt_pkg::*; #(
	parameter int INT_WIDTH = 32,
	parameter int PTR_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [2:0]  req_type,
	input  logic [63:0] value,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  out_char,
	output logic        last_char
);

	localparam int OCT_ND  = (INT_WIDTH + 2) / 3;
	localparam int HEXI_ND = (INT_WIDTH + 3) / 4;
	localparam int HEXP_ND = (PTR_WIDTH + 3) / 4;
	localparam int BCD_ND  = (INT_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W   = BCD_ND * 4;
	localparam int BIN_W   = max_int(max_int(OCT_ND * 3, HEXI_ND * 4),
		max_int(HEXP_ND * 4, BCD_W));
	localparam int DEC_SH  = BIN_W - INT_WIDTH;
	localparam int OCT_SH  = BIN_W - OCT_ND * 3;
	localparam int HEXI_SH = BIN_W - HEXI_ND * 4;
	localparam int HEXP_SH = BIN_W - HEXP_ND * 4;
	localparam int BCD_SH  = BIN_W - BCD_W;
	localparam int CNT_W   = $clog2(BIN_W + 1);
	localparam int STEP_W  = $clog2(INT_WIDTH + 1);

	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	dmode_t               mode_q;
	pre_t                 pre_q;
	logic [2:0]           pre_idx_q;
	logic [CNT_W-1:0]     dig_cnt_q;
	logic [STEP_W-1:0]    step_cnt_q;
	logic [EMIT_W-1:0]    emit_cnt_q;
	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 last_q;

	logic [INT_WIDTH-1:0] in_ival;
	logic [INT_WIDTH-1:0] in_mag;
	logic [PTR_WIDTH-1:0] in_ptr;
	logic                 in_neg;
	logic [3:0]           top_digit;
	logic                 emit;
	logic                 pre_last;
	logic                 trunc;

	always_comb begin
		in_ival = value[INT_WIDTH-1:0];
		in_ptr  = value[PTR_WIDTH-1:0];
		in_neg  = (req_type == KIND_SDEC) && in_ival[INT_WIDTH-1];
		// Two's complement negation in INT_WIDTH bits covers the most negative value.
		in_mag  = in_neg ? (~in_ival + INT_WIDTH'(1)) : in_ival;
	end

	// Add-3 correction of every BCD digit before the next shift.
	always_comb begin
		logic [3:0] d;
		for (int i = 0; i < BCD_ND; i++) begin
			d = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	assign top_digit = (mode_q == DM_OCT) ? {1'b0, bin_q[BIN_W-1 -: 3]} : bin_q[BIN_W-1 -: 4];
	assign emit      = cmd.emit_pre || cmd.emit_dig;
	assign pre_last  = (pre_idx_q == prefix_len(pre_q) - 3'd1);
	assign trunc     = (emit_cnt_q == EMIT_W'(MAX_RESULTS - 1));

	always_comb begin
		stat.kind_ok   = 1'b0;
		stat.in_dec    = 1'b0;
		unique case (req_type) inside
			KIND_SDEC, KIND_UDEC: begin
				stat.kind_ok = 1'b1;
				stat.in_dec  = 1'b1;
			end
			KIND_OCT, KIND_HEX, KIND_PTR: stat.kind_ok = 1'b1;
			default: stat.kind_ok = 1'b0;
		endcase
		stat.conv_last = (step_cnt_q == STEP_W'(1));
		stat.skip_done = (top_digit != 4'd0) || (dig_cnt_q == CNT_W'(1));
		stat.has_pre   = (pre_q != PRE_NONE);
		stat.pre_last  = pre_last;
		stat.pre_end   = pre_last && (pre_q == PRE_NULL);
		stat.dig_last  = (dig_cnt_q == CNT_W'(1));
		stat.trunc     = trunc;
		stat.emit_ok   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			step_cnt_q <= STEP_W'(INT_WIDTH);
			bcd_q      <= '0;
			pre_idx_q  <= '0;
			emit_cnt_q <= '0;
			unique case (req_type) inside
				KIND_SDEC, KIND_UDEC: begin
					mode_q    <= DM_DEC;
					bin_q     <= BIN_W'(in_mag) << DEC_SH;
					pre_q     <= in_neg ? PRE_MINUS : PRE_NONE;
					dig_cnt_q <= CNT_W'(BCD_ND);
				end
				KIND_OCT: begin
					mode_q    <= DM_OCT;
					bin_q     <= BIN_W'(in_ival) << OCT_SH;
					pre_q     <= PRE_NONE;
					dig_cnt_q <= CNT_W'(OCT_ND);
				end
				KIND_HEX: begin
					mode_q    <= DM_HEXU;
					bin_q     <= BIN_W'(in_ival) << HEXI_SH;
					pre_q     <= PRE_NONE;
					dig_cnt_q <= CNT_W'(HEXI_ND);
				end
				KIND_PTR: begin
					mode_q    <= DM_HEXL;
					bin_q     <= BIN_W'(in_ptr) << HEXP_SH;
					pre_q     <= (in_ptr == '0) ? PRE_NULL : PRE_HEX;
					dig_cnt_q <= CNT_W'(HEXP_ND);
				end
				default: begin
					pre_q <= PRE_NONE;
				end
			endcase
		end else begin
			if (cmd.conv_step) begin
				bcd_q      <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
				bin_q      <= bin_q << 1;
				step_cnt_q <= step_cnt_q - STEP_W'(1);
			end else if (cmd.bcd_move) begin
				bin_q <= BIN_W'(bcd_q) << BCD_SH;
			end else if (cmd.skip || cmd.emit_dig) begin
				bin_q     <= (mode_q == DM_OCT) ? (bin_q << 3) : (bin_q << 4);
				dig_cnt_q <= dig_cnt_q - CNT_W'(1);
			end
			if (cmd.emit_pre)
				pre_idx_q <= pre_idx_q + 3'd1;
			if (emit && !trunc)
				emit_cnt_q <= emit_cnt_q + EMIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pre) begin
			out_char_q <= prefix_char(pre_q, pre_idx_q);
			last_q     <= trunc || (pre_last && (pre_q == PRE_NULL));
		end else if (cmd.emit_dig) begin
			out_char_q <= digit_char(top_digit, mode_q == DM_HEXL);
			last_q     <= trunc || (dig_cnt_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	a_emit_space: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("character written while the output register was held");

	a_dig_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_dig || cmd.skip) |-> (dig_cnt_q != '0))
		else $error("digit consumed with no digits left");

	a_conv_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_step |-> (step_cnt_q != '0))
		else $error("BCD conversion step past the last input bit");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.conv_step, cmd.bcd_move, cmd.skip, cmd.emit_pre, cmd.emit_dig}))
		else $error("more than one datapath command in a cycle");

endmodule

### hdl/i2afmt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2afmt_ctrl: formatter controller
// Sequences accept, BCD conversion, leading-zero skip, prefix and digit
// emission, and drives the input ready.
// ----------------------------------------------------------------------------
module i2afmt_ctrl import i2afmt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	fsm_state_t state_q;
	fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// Unknown kinds produce no text and leave the block idle.
					if (stat.kind_ok)
						state_d = stat.in_dec ? ST_CONV : ST_SKIP;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_last)
					state_d = ST_MOVE;
			end
			ST_MOVE: begin
				cmd.bcd_move = 1'b1;
				state_d      = ST_SKIP;
			end
			ST_SKIP: begin
				if (stat.skip_done)
					state_d = stat.has_pre ? ST_PREFIX : ST_DIGITS;
				else
					cmd.skip = 1'b1;
			end
			ST_PREFIX: begin
				if (stat.emit_ok) begin
					cmd.emit_pre = 1'b1;
					if (stat.trunc || stat.pre_end)
						state_d = ST_IDLE;
					else if (stat.pre_last)
						state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (stat.emit_ok) begin
					cmd.emit_dig = 1'b1;
					if (stat.trunc || stat.dig_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
